// File: design/assert_macros.svh
// assertion macros shared by the drive pipeline modules
// no dependencies; each file that asserts pulls this in by include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define CHK_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define CHK_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/crsfhb_pkg.sv
// shared constants and types for the rc-frame to h-bridge drive block
// no dependencies
`default_nettype none

package crsfhb_pkg;

  localparam int BYTE_W = 8;
  localparam int CHAN_W = 11;
  localparam int HIGH_W = CHAN_W - BYTE_W;

  localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hC8;
  localparam logic [BYTE_W-1:0] TYPE_CHANNELS = 8'h16;

  localparam int CENTRE            = 1024;
  localparam int FULL_DUTY         = 255;
  localparam int DEAD_BAND_DEFAULT = 100;

  // reciprocal precision: 18-bit dividend plus up to 10-bit divisor
  localparam int RECIP_SHIFT = 28;

  // channel request from the parser to the drive stage
  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] chan;
  } chan_req_t;

endpackage

`default_nettype wire

// File: design/crsfhb_parser.sv
// byte-level frame parser: sync hunt, length, type and channel 0 capture
// depends on crsfhb_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module crsfhb_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [crsfhb_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                          chan_stall,
  output crsfhb_pkg::chan_req_t              chan_req
);
  import crsfhb_pkg::*;

  logic [BYTE_W-1:0] byte_position;
  logic [BYTE_W-1:0] frame_length;
  logic [BYTE_W-1:0] frame_type;
  logic [BYTE_W-1:0] payload_low;
  logic [HIGH_W-1:0] payload_high_bits;
  logic              chan_valid;
  logic [CHAN_W-1:0] chan_value;

  logic              accept;
  logic [BYTE_W-1:0] pos_inc;
  logic [BYTE_W-1:0] type_now;
  logic [BYTE_W-1:0] low_now;
  logic [HIGH_W-1:0] high_now;
  logic              in_body;
  logic              frame_end;
  logic              emit;

  assign chan_req = '{valid: chan_valid, chan: chan_value};

  assign in_stall = chan_valid && chan_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos_inc   = byte_position + 8'd1;
    in_body   = byte_position >= 8'd2;
    type_now  = (byte_position == 8'd2) ? rx_byte : frame_type;
    low_now   = (byte_position == 8'd3) ? rx_byte : payload_low;
    high_now  = (byte_position == 8'd4) ? rx_byte[HIGH_W-1:0] : payload_high_bits;
    // compare in 9 bits so length plus 2 does not wrap
    frame_end = {1'b0, pos_inc} >= ({1'b0, frame_length} + 9'd2);
    emit      = in_body && frame_end && (type_now == TYPE_CHANNELS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      frame_length      <= '0;
      frame_type        <= '0;
      payload_low       <= '0;
      payload_high_bits <= '0;
    end else if (accept) begin
      if (byte_position == 8'd0) begin
        if (rx_byte == SYNC_BYTE) begin
          byte_position <= 8'd1;
        end
      end else if (byte_position == 8'd1) begin
        frame_length  <= rx_byte;
        byte_position <= 8'd2;
      end else begin
        frame_type        <= type_now;
        payload_low       <= low_now;
        payload_high_bits <= high_now;
        byte_position     <= frame_end ? 8'd0 : pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_valid <= 1'b0;
    end else if (!in_stall) begin
      chan_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      chan_value <= {high_now, low_now};
    end
  end

  `CHK_NEXT(a_hunt_drop, clk, rst,
            accept && (byte_position == 8'd0) && (rx_byte != SYNC_BYTE),
            byte_position == 8'd0, "non-sync byte left hunt state")
  `CHK_IMPLY(a_req_from_accept, clk, rst, $rose(chan_valid), $past(accept),
             "channel request without an accepted byte")

endmodule

`default_nettype wire

// File: design/crsfhb_drive.sv
// deadband, direction hold and duty scaling into the result register
// depends on crsfhb_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module crsfhb_drive #(
  parameter int DEAD_BAND = crsfhb_pkg::DEAD_BAND_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire crsfhb_pkg::chan_req_t         chan_req,
  output logic                               chan_stall,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               direction,
  output logic [crsfhb_pkg::BYTE_W-1:0]      duty,
  output logic [crsfhb_pkg::CHAN_W-1:0]      channel_raw
);
  import crsfhb_pkg::*;

  localparam logic [CHAN_W:0] UP_BOUND = (CHAN_W + 1)'(CENTRE + DEAD_BAND);
  localparam logic [CHAN_W:0] LO_BOUND = (CHAN_W + 1)'(CENTRE - DEAD_BAND);
  localparam logic [39:0]     DIVISOR  = 40'(CENTRE - DEAD_BAND);
  // rounded-up reciprocal, exact floor for every dividend below 2^18
  localparam logic [39:0]     RECIP    = ((40'd1 << RECIP_SHIFT) + DIVISOR - 40'd1) / DIVISOR;
  localparam logic [31:0]     SCALE    = 32'(RECIP * 40'(FULL_DUTY));
  localparam int              PROD_W   = CHAN_W + 32;

  logic                load;
  logic [CHAN_W:0]     chan_ext;
  logic                above;
  logic                below;
  logic [CHAN_W:0]     excess;
  logic [PROD_W-1:0]   prod;
  logic [BYTE_W-1:0]   duty_next;

  assign chan_stall = out_valid && out_stall;
  assign load       = chan_req.valid && !chan_stall;

  always_comb begin
    chan_ext  = {1'b0, chan_req.chan};
    above     = chan_ext > UP_BOUND;
    below     = chan_ext < LO_BOUND;
    excess    = above ? (chan_ext - UP_BOUND) : (LO_BOUND - chan_ext);
    prod      = PROD_W'(excess[CHAN_W-1:0]) * PROD_W'(SCALE);
    duty_next = (above || below) ? prod[RECIP_SHIFT +: BYTE_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      direction <= 1'b0;
    end else begin
      if (!chan_stall) begin
        out_valid <= chan_req.valid;
      end
      if (load && above) begin
        direction <= 1'b1;
      end else if (load && below) begin
        direction <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty        <= duty_next;
      channel_raw <= chan_req.chan;
    end
  end

  `CHK_IMPLY(a_duty_dir, clk, rst, out_valid && (duty != 8'd0),
             direction == ({1'b0, channel_raw} > UP_BOUND),
             "nonzero duty with wrong direction")
  `CHK_IMPLY(a_band_zero, clk, rst,
             out_valid && ({1'b0, channel_raw} <= UP_BOUND) && ({1'b0, channel_raw} >= LO_BOUND),
             duty == 8'd0, "duty inside deadband")

endmodule

`default_nettype wire

// File: design/crsf_channel_to_hbridge_drive.sv
// top level: rc-channels frame parser driving an h-bridge from channel 0
// depends on crsfhb_pkg, crsfhb_parser and crsfhb_drive
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------------------
//   in      | in_valid  | in_stall  | rx_byte
//   out     | out_valid | out_stall | direction, duty, channel_raw
//
// one received byte per cycle while in_stall is low; the byte that ends a type
// 0x16 frame gives a result through the parser register, then the result register
// synchronous reset puts the parser back to sync hunt and clears all frame state
// in_stall rises only when both the channel register and the result register
// hold requests and the result is stalled; otherwise bytes flow every cycle
`default_nettype none

module crsf_channel_to_hbridge_drive #(
  parameter int DEAD_BAND = crsfhb_pkg::DEAD_BAND_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [crsfhb_pkg::BYTE_W-1:0] rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               direction,
  output logic [crsfhb_pkg::BYTE_W-1:0]      duty,
  output logic [crsfhb_pkg::CHAN_W-1:0]      channel_raw
);
  import crsfhb_pkg::*;

  // channel 0 request between parser and drive stage
  chan_req_t chan_req;
  logic      chan_stall;

  // sync hunt, length and position counting, payload capture
  crsfhb_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .chan_stall (chan_stall),
    .chan_req   (chan_req)
  );

  // centering, deadband, direction hold and duty scaling
  crsfhb_drive #(
    .DEAD_BAND (DEAD_BAND)
  ) u_drive (
    .clk         (clk),
    .rst         (rst),
    .chan_req    (chan_req),
    .chan_stall  (chan_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .direction   (direction),
    .duty        (duty),
    .channel_raw (channel_raw)
  );

endmodule

`default_nettype wire
